>>> hw/rtl/mstb_pkg.sv
`default_nettype none

package mstb_pkg;

    // Field widths of one input beat and one result beat.
    localparam int unsigned OP_W    = 2;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned PRE_W   = 8;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    typedef logic [OP_W-1:0]       t_op;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [PRE_W-1:0]      t_pre;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Operation codes carried in the op field.
    localparam t_op OP_TICK         = 2'd0;
    localparam t_op OP_SET_DEADLINE = 2'd1;
    localparam t_op OP_POLL         = 2'd2;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_SLOW_PERIOD = 2'd0;
    localparam t_cfg_idx CFG_NOISE_PHASE = 2'd1;

    // Reset values.
    localparam t_pre   SLOW_PERIOD_RST = 8'd50;
    localparam t_pre   NOISE_PHASE_RST = 8'd25;
    localparam t_count DEADLINE_OFF    = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

>>> hw/rtl/mstb_in_if.sv
`default_nettype none

interface mstb_in_if;
    import mstb_pkg::*;

    logic   valid;
    logic   ready;
    t_op    op;
    t_count delay_ms;

    modport source (output valid, output op, output delay_ms, input ready);
    modport sink   (input valid, input op, input delay_ms, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mstb_out_if.sv
`default_nettype none

interface mstb_out_if;
    import mstb_pkg::*;

    logic   valid;
    logic   ready;
    t_count ms_count;
    logic   slow_flag_seen;
    logic   deadline_hit;
    logic   noise_start;

    modport source (
        output valid, output ms_count, output slow_flag_seen,
        output deadline_hit, output noise_start, input ready
    );
    modport sink (
        input valid, input ms_count, input slow_flag_seen,
        input deadline_hit, input noise_start, output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/ms_timebase_with_deadline.sv
`default_nettype none

// Millisecond timebase with a slow-flag prescaler and a deadline compare.
//
// Input channel i_in carries one beat per operation: a tick advances the
// 32-bit count and the 8-bit prescaler, a set-deadline beat arms the deadline
// at count plus delay_ms (zero disarms it), and a poll beat reports and clears
// the sticky slow flag. Every input beat yields exactly one result beat on
// o_out, carrying the count after the operation and three flag bits.
//
// The result of a beat accepted at one clock edge is presented on o_out
// right after that edge. Throughput is one beat per cycle while the receiver
// takes results; all state is updated by a single increment, a decrement,
// an add and one 32-bit compare between the state registers and the result register.
//
// When the receiver stalls, the result register holds its beat and i_in.ready
// drops only while that register is full and not being taken, so a new beat
// enters in the same cycle in which the previous result leaves.
// The synchronous active-low reset clears the count and the slow flag, disarms
// the deadline, reloads the prescaler with 50 and restores both registers.

module ms_timebase_with_deadline (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  mstb_pkg::t_cfg_idx   i_cfg_idx,
    input  mstb_pkg::t_cfg_data  i_cfg_data,
    mstb_in_if.sink              i_in,
    mstb_out_if.source           o_out
);
    import mstb_pkg::*;

    // Configuration registers. A write takes effect at its edge; an index
    // past the last register is ignored.
    t_pre   r_slow_period;
    t_pre   r_noise_phase;

    // Timebase state.
    t_count r_tick_count, n_tick_count;
    t_pre   r_prescale,   n_prescale;
    logic   r_slow_flag,  n_slow_flag;
    t_count r_deadline,   n_deadline;

    // Result register.
    logic   r_out_valid,  n_out_valid;
    t_count r_ms_count,   n_ms_count;
    logic   r_seen,       n_seen;
    logic   r_hit,        n_hit;
    logic   r_noise,      n_noise;

    logic   accept;
    t_count count_inc;
    t_pre   pre_dec;
    t_pre   pre_next;

    // The result stage frees up whenever its beat is taken.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign count_inc = r_tick_count + t_count'(1);
    assign pre_dec   = r_prescale - t_pre'(1);
    // On reaching zero the prescaler reloads the period in the same tick.
    assign pre_next  = (pre_dec == '0) ? r_slow_period : pre_dec;

    always_comb begin
        n_tick_count = r_tick_count;
        n_prescale   = r_prescale;
        n_slow_flag  = r_slow_flag;
        n_deadline   = r_deadline;
        n_out_valid  = r_out_valid;
        n_ms_count   = r_ms_count;
        n_seen       = r_seen;
        n_hit        = r_hit;
        n_noise      = r_noise;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (accept) begin
            n_out_valid = 1'b1;
            n_ms_count  = r_tick_count;
            n_seen      = 1'b0;
            n_hit       = 1'b0;
            n_noise     = 1'b0;
            case (i_in.op)
                OP_TICK: begin
                    n_tick_count = count_inc;
                    n_prescale   = pre_next;
                    if (pre_dec == '0) begin
                        n_slow_flag = 1'b1;
                    end
                    n_ms_count = count_inc;
                    // Plain unsigned compare, so an all-ones deadline still
                    // hits when the count itself is all ones.
                    n_hit      = (count_inc >= r_deadline);
                    n_noise    = (pre_next == r_noise_phase);
                end
                OP_SET_DEADLINE: begin
                    if (i_in.delay_ms != '0) begin
                        n_deadline = r_tick_count + i_in.delay_ms;
                    end else begin
                        n_deadline = DEADLINE_OFF;
                    end
                end
                OP_POLL: begin
                    n_seen      = r_slow_flag;
                    n_slow_flag = 1'b0;
                end
                default: begin
                    // Unused code: state is left alone, flags stay low.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_period <= SLOW_PERIOD_RST;
            r_noise_phase <= NOISE_PHASE_RST;
            r_tick_count  <= '0;
            r_prescale    <= SLOW_PERIOD_RST;
            r_slow_flag   <= 1'b0;
            r_deadline    <= DEADLINE_OFF;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SLOW_PERIOD: r_slow_period <= i_cfg_data;
                    CFG_NOISE_PHASE: r_noise_phase <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_tick_count <= n_tick_count;
            r_prescale   <= n_prescale;
            r_slow_flag  <= n_slow_flag;
            r_deadline   <= n_deadline;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload carries no reset.
    always_ff @(posedge i_clk) begin
        r_ms_count <= n_ms_count;
        r_seen     <= n_seen;
        r_hit      <= n_hit;
        r_noise    <= n_noise;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.ms_count       = r_ms_count;
    assign o_out.slow_flag_seen = r_seen;
    assign o_out.deadline_hit   = r_hit;
    assign o_out.noise_start    = r_noise;

endmodule

`default_nettype wire

>>> verif/ms_timebase_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the timebase, keeps its own copy of the counter,
// prescaler, slow flag and deadline, and compares each result beat with
// the oldest outstanding prediction.
module ms_timebase_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  mstb_pkg::t_cfg_idx  i_cfg_idx,
    input  mstb_pkg::t_cfg_data i_cfg_data,
    mstb_in_if                  i_in,
    mstb_out_if                 i_out,
    output int                  o_errors,
    output int                  o_outstanding
);
    import mstb_pkg::*;

    typedef struct packed {
        t_count ms_count;
        logic   slow_flag_seen;
        logic   deadline_hit;
        logic   noise_start;
    } t_timebase_result;

    t_pre             slow_period;
    t_pre             noise_phase;
    t_count           tick_count;
    t_pre             prescale_left;
    logic             slow_flag;
    t_count           deadline;
    t_timebase_result expected_results[$];

    // Applies one operation to the mirrored state and returns its result.
    function automatic t_timebase_result step_timebase(t_op op, t_count delay);
        t_timebase_result res;
        res = '0;
        case (op)
            OP_TICK: begin
                tick_count    = tick_count + 1'b1;
                prescale_left = prescale_left - 1'b1;
                if (prescale_left == '0) begin
                    prescale_left = slow_period;
                    slow_flag     = 1'b1;
                end
                res.deadline_hit = (tick_count >= deadline);
                res.noise_start  = (prescale_left == noise_phase);
            end
            OP_SET_DEADLINE: begin
                deadline = (delay != '0) ? tick_count + delay : DEADLINE_OFF;
            end
            OP_POLL: begin
                res.slow_flag_seen = slow_flag;
                slow_flag          = 1'b0;
            end
            default: ;
        endcase
        res.ms_count = tick_count;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_timebase_result want;
        if (!i_rst_n) begin
            slow_period   = SLOW_PERIOD_RST;
            noise_phase   = NOISE_PHASE_RST;
            tick_count    = '0;
            prescale_left = SLOW_PERIOD_RST;
            slow_flag     = 1'b0;
            deadline      = DEADLINE_OFF;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SLOW_PERIOD: slow_period = i_cfg_data;
                    CFG_NOISE_PHASE: noise_phase = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat: ms_count %0d", i_out.ms_count);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.ms_count !== want.ms_count) begin
                        $error("ms_count: expected %0d, actual %0d",
                               want.ms_count, i_out.ms_count);
                        o_errors++;
                    end
                    if (i_out.slow_flag_seen !== want.slow_flag_seen) begin
                        $error("slow_flag_seen: expected %0b, actual %0b",
                               want.slow_flag_seen, i_out.slow_flag_seen);
                        o_errors++;
                    end
                    if (i_out.deadline_hit !== want.deadline_hit) begin
                        $error("deadline_hit: expected %0b, actual %0b",
                               want.deadline_hit, i_out.deadline_hit);
                        o_errors++;
                    end
                    if (i_out.noise_start !== want.noise_start) begin
                        $error("noise_start: expected %0b, actual %0b",
                               want.noise_start, i_out.noise_start);
                        o_errors++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_results.push_back(step_timebase(i_in.op, i_in.delay_ms));
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the millisecond timebase. The checker instance
// beside the block does all prediction and comparison; this module only
// drives the input channel, the result channel's ready and the register
// port, then reports the outcome.
module tb;
    import mstb_pkg::*;

    // Codes the block must ignore: the spare op code and the register
    // indexes past the last real register.
    localparam t_op      OP_UNUSED   = 2'd3;
    localparam t_cfg_idx CFG_SPARE_2 = 2'd2;
    localparam t_cfg_idx CFG_SPARE_3 = 2'd3;

    // Roughly 1050 beats are sent; the limit is many times the slowest legal
    // run, with idle gaps and receiver stalls included.
    localparam int CYCLE_LIMIT    = 200_000;
    localparam int PHASE_BEATS    = 172;
    localparam int IDLE_PERCENT   = 26;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg_data i_cfg_data;
    bit        calm;
    int        cycle_cnt;
    int        chk_errors;
    int        chk_outstanding;

    mstb_in_if  in_bus ();
    mstb_out_if out_bus ();

    ms_timebase_with_deadline i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    ms_timebase_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in          (in_bus),
        .i_out         (out_bus),
        .o_errors      (chk_errors),
        .o_outstanding (chk_outstanding)
    );

    always #5 i_clk = ~i_clk;

    // The receiver stalls about a quarter of the time, except during the
    // calm stretch where it takes every result beat at once.
    always @(negedge i_clk) begin
        out_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL ms_timebase_with_deadline");
            $finish;
        end
    end

    // Presents one beat, with random idle cycles in front of it unless the
    // calm stretch is on, and returns at the edge where it is accepted.
    // All input changes land on the falling edge, so the block and the
    // checker always sample settled values at the rising edge.
    task automatic send_beat(input t_op op, input t_count delay);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        in_bus.valid    <= 1'b1;
        in_bus.op       <= op;
        in_bus.delay_ms <= delay;
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    // Holds the sender off until every predicted result has been taken,
    // then lets the single-register pipeline settle.
    task automatic drain_results();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (chk_outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Delays lean toward small values so the deadline is actually reached
    // by ticks, with zero (disarm), full-range values and values just below
    // all-ones (a deadline that wraps past zero and hits at once) mixed in.
    function automatic t_count pick_delay();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return $urandom;
            3:       return DEADLINE_OFF - $urandom_range(0, 300);
            default: return $urandom_range(1, 120);
        endcase
    endfunction

    // Ticks dominate so the prescaler keeps turning over; deadline sets,
    // polls and the spare op code fill the rest.
    function automatic t_op pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 68) begin
            return OP_TICK;
        end else if (roll < 80) begin
            return OP_SET_DEADLINE;
        end else if (roll < 93) begin
            return OP_POLL;
        end
        return OP_UNUSED;
    endfunction

    initial begin
        t_cfg_data phase_period [6];
        t_cfg_data phase_noise  [6];
        t_cfg_data period;
        t_cfg_data noise;

        // Register settings per random phase: a period of one (flag on every
        // reload), a period of zero (the prescaler wraps to 255 after the
        // reload), the top values, a short ordinary period, a random pick
        // and a last one preceded by writes to the spare indexes.
        phase_period = '{8'd1, 8'd0, 8'd255, 8'd7, 8'd1, 8'd3};
        phase_noise  = '{8'd0, 8'd0, 8'd255, 8'd3, 8'd0, 8'd2};

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_SLOW_PERIOD;
        i_cfg_data      = '0;
        in_bus.valid    = 1'b0;
        in_bus.op       = OP_TICK;
        in_bus.delay_ms = '0;
        out_bus.ready   = 1'b0;
        calm            = 1'b0;
        cycle_cnt       = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings: every op, the delay extremes,
        // a deadline reached by ticks, a disarmed deadline, a deadline that
        // wraps past zero and so hits on the very next tick, and the spare
        // op code with both extremes on the ignored delay field.
        send_beat(OP_TICK, '0);
        send_beat(OP_POLL, DEADLINE_OFF);
        send_beat(OP_SET_DEADLINE, 32'd3);
        repeat (4) send_beat(OP_TICK, '0);
        send_beat(OP_SET_DEADLINE, '0);
        send_beat(OP_TICK, '0);
        send_beat(OP_SET_DEADLINE, DEADLINE_OFF);
        send_beat(OP_TICK, '0);
        send_beat(OP_SET_DEADLINE, 32'h8000_0000);
        send_beat(OP_TICK, '0);
        send_beat(OP_UNUSED, DEADLINE_OFF);
        send_beat(OP_UNUSED, '0);
        send_beat(OP_SET_DEADLINE, 32'h5555_5555);
        send_beat(OP_SET_DEADLINE, 32'hAAAA_AAAA);
        send_beat(OP_SET_DEADLINE, 32'd1);
        send_beat(OP_TICK, DEADLINE_OFF);
        send_beat(OP_POLL, '0);
        send_beat(OP_TICK, '0);
        drain_results();

        for (int ph = 0; ph < 6; ph++) begin
            period = phase_period[ph];
            noise  = phase_noise[ph];
            if (ph == 4) begin
                period = t_cfg_data'($urandom_range(1, 255));
                noise  = t_cfg_data'($urandom_range(0, period));
            end
            // Writes to the spare indexes carry values that would upset the
            // prediction if the block failed to ignore them.
            if (ph == 5) begin
                write_reg(CFG_SPARE_2, 8'hFF);
                write_reg(CFG_SPARE_3, 8'h00);
            end
            write_reg(CFG_SLOW_PERIOD, period);
            write_reg(CFG_NOISE_PHASE, noise);

            // One whole phase runs with neither side idling.
            calm = (ph == 2);

            for (int k = 0; k < PHASE_BEATS; k++) begin
                send_beat(pick_op(), pick_delay());
                // Now and then the sender waits for the pipe to empty and
                // changes the period while the prescaler is mid-count; the
                // new value only matters at the next reload.
                if ($urandom_range(0, 149) == 0) begin
                    drain_results();
                    write_reg(CFG_SLOW_PERIOD, t_cfg_data'($urandom_range(0, 255)));
                end
            end
            drain_results();
        end

        if (chk_errors == 0) begin
            $display("PASS ms_timebase_with_deadline");
        end else begin
            $display("FAIL ms_timebase_with_deadline");
        end
        $finish;
    end

endmodule

>>> ms_timebase_with_deadline.f
hw/rtl/mstb_pkg.sv
hw/rtl/mstb_in_if.sv
hw/rtl/mstb_out_if.sv
hw/rtl/ms_timebase_with_deadline.sv
verif/ms_timebase_checker.sv
verif/tb.sv
